// ===== rtl/core/pdbb_pkg.sv =====
// ----------------------------------------------------------------------------
// pdbb_pkg: shared types and constants of the pixel difference box block
// Payload structs, configuration register indexes, reset values and widths.
// ----------------------------------------------------------------------------
package pdbb_pkg;

  localparam int unsigned PIX_W      = 32;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned NUM_CHAN   = PIX_W / CHAN_W;
  localparam int unsigned TOL_W      = 8;
  localparam int unsigned SIZE_W     = 12;
  localparam int unsigned COUNT_W    = 23;
  localparam int unsigned COORD_W    = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  localparam int unsigned DEF_MAX_WIDTH  = 2048;
  localparam int unsigned DEF_MAX_HEIGHT = 2048;

  localparam logic [TOL_W-1:0]  TOL_RESET    = 8'd0;
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 12'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOLERANCE    = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [PIX_W-1:0] left_pixel;
    logic [PIX_W-1:0] right_pixel;
  } pdbb_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] changed_count;
    logic               any_changed;
    logic [COORD_W-1:0] box_min_x;
    logic [COORD_W-1:0] box_min_y;
    logic [COORD_W-1:0] box_max_x;
    logic [COORD_W-1:0] box_max_y;
  } pdbb_out_t;

  // Pixel stage to accumulator: one registered verdict per pixel pair
  typedef struct packed {
    logic valid;
    logic changed;
  } pdbb_stage_t;

endpackage

// ===== rtl/core/pdbb_diff.sv =====
// ----------------------------------------------------------------------------
// pdbb_diff: pixel compare stage
// Takes the largest channel difference of a pixel pair, compares it with the
// tolerance and registers the changed verdict for the accumulator.
// ----------------------------------------------------------------------------
module pdbb_diff
  import pdbb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [TOL_W-1:0]  tolerance_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pdbb_in_t          in_data_i,
  input  logic              advance_i,
  output pdbb_stage_t       stage_o
);

  logic [CHAN_W-1:0] gap   [NUM_CHAN];
  logic [CHAN_W-1:0] max_ab, max_cd, max_gap;
  logic              accept;
  logic              valid_d, valid_q;
  logic              changed_q;

  always_comb begin
    for (int unsigned c = 0; c < NUM_CHAN; c++) begin
      logic [CHAN_W-1:0] a, b;
      a = in_data_i.left_pixel[c*CHAN_W +: CHAN_W];
      b = in_data_i.right_pixel[c*CHAN_W +: CHAN_W];
      gap[c] = (a > b) ? (a - b) : (b - a);
    end
  end

  assign max_ab  = (gap[0] > gap[1]) ? gap[0] : gap[1];
  assign max_cd  = (gap[2] > gap[3]) ? gap[2] : gap[3];
  assign max_gap = (max_ab > max_cd) ? max_ab : max_cd;

  // Hold the stage while the accumulator cannot take it
  assign in_stall_o = valid_q & ~advance_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      changed_q <= (max_gap > tolerance_i);
    end
  end

  assign stage_o.valid   = valid_q;
  assign stage_o.changed = changed_q;

endmodule

// ===== rtl/core/pdbb_accum.sv =====
// ----------------------------------------------------------------------------
// pdbb_accum: frame accumulator and result register
// Tracks the raster position, counts changed pixels, grows the bounding box
// and loads the result register at the last pixel of each frame.
// ----------------------------------------------------------------------------
module pdbb_accum
  import pdbb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SIZE_W-1:0] frame_width_i,
  input  logic [SIZE_W-1:0] frame_height_i,
  input  pdbb_stage_t       stage_i,
  output logic              advance_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pdbb_out_t         out_data_o
);

  localparam int unsigned XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned SXW = ($clog2(MAX_WIDTH + 1) > SIZE_W) ?
                                $clog2(MAX_WIDTH + 1) : SIZE_W;
  localparam int unsigned SYW = ($clog2(MAX_HEIGHT + 1) > SIZE_W) ?
                                $clog2(MAX_HEIGHT + 1) : SIZE_W;

  logic [SXW-1:0]     fw_ext, w_lim;
  logic [SYW-1:0]     fh_ext, h_lim;
  logic               last_col, last_row, last_pix;

  logic [XW-1:0]      col_d, col_q;
  logic [YW-1:0]      row_d, row_q;
  logic [COUNT_W-1:0] cnt_d, cnt_q, cnt_n;
  logic               found_d, found_q, found_n;
  logic [XW-1:0]      lx_d, lx_q, lx_n, hx_d, hx_q, hx_n;
  logic [YW-1:0]      ly_d, ly_q, ly_n, hy_d, hy_q, hy_n;
  logic               out_valid_d, out_valid_q;
  pdbb_out_t          out_d, out_q;
  logic               load_out;

  // Clamp the frame size: zero acts as one, large values as the maximum
  assign fw_ext = SXW'(frame_width_i);
  assign fh_ext = SYW'(frame_height_i);
  assign w_lim  = (fw_ext == '0) ? SXW'(1) :
                  (fw_ext > SXW'(MAX_WIDTH)) ? SXW'(MAX_WIDTH) : fw_ext;
  assign h_lim  = (fh_ext == '0) ? SYW'(1) :
                  (fh_ext > SYW'(MAX_HEIGHT)) ? SYW'(MAX_HEIGHT) : fh_ext;

  assign last_col = (SXW'(col_q) + SXW'(1)) >= w_lim;
  assign last_row = (SYW'(row_q) + SYW'(1)) >= h_lim;
  assign last_pix = last_col & last_row;

  // A frame end needs a free result register; other pixels always move on
  assign advance_o = stage_i.valid & (~last_pix | ~out_valid_q | ~out_stall_i);
  assign load_out  = advance_o & last_pix;

  // Accumulators including the current pixel
  always_comb begin
    cnt_n   = cnt_q;
    found_n = found_q;
    lx_n    = lx_q;
    hx_n    = hx_q;
    ly_n    = ly_q;
    hy_n    = hy_q;
    if (stage_i.changed) begin
      if (cnt_q != '1) begin
        cnt_n = cnt_q + COUNT_W'(1);
      end
      found_n = 1'b1;
      if (!found_q) begin
        lx_n = col_q;
        hx_n = col_q;
        ly_n = row_q;
        hy_n = row_q;
      end else begin
        if (col_q < lx_q) lx_n = col_q;
        if (col_q > hx_q) hx_n = col_q;
        if (row_q < ly_q) ly_n = row_q;
        if (row_q > hy_q) hy_n = row_q;
      end
    end
  end

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    cnt_d   = cnt_q;
    found_d = found_q;
    lx_d    = lx_q;
    hx_d    = hx_q;
    ly_d    = ly_q;
    hy_d    = hy_q;
    if (advance_o) begin
      if (last_pix) begin
        // Clear for the next frame
        col_d   = '0;
        row_d   = '0;
        cnt_d   = '0;
        found_d = 1'b0;
        lx_d    = '0;
        hx_d    = '0;
        ly_d    = '0;
        hy_d    = '0;
      end else begin
        cnt_d   = cnt_n;
        found_d = found_n;
        lx_d    = lx_n;
        hx_d    = hx_n;
        ly_d    = ly_n;
        hy_d    = hy_n;
        if (last_col) begin
          col_d = '0;
          row_d = row_q + YW'(1);
        end else begin
          col_d = col_q + XW'(1);
        end
      end
    end
  end

  always_comb begin
    out_d.changed_count = cnt_n;
    out_d.any_changed   = found_n;
    out_d.box_min_x     = found_n ? COORD_W'(lx_n) : '0;
    out_d.box_min_y     = found_n ? COORD_W'(ly_n) : '0;
    out_d.box_max_x     = found_n ? COORD_W'(hx_n) : '0;
    out_d.box_max_y     = found_n ? COORD_W'(hy_n) : '0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
      lx_q        <= '0;
      hx_q        <= '0;
      ly_q        <= '0;
      hy_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      cnt_q       <= cnt_d;
      found_q     <= found_d;
      lx_q        <= lx_d;
      hx_q        <= hx_d;
      ly_q        <= ly_d;
      hy_q        <= hy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_frame_end_loads_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_q
  ) else $error("frame end did not load the result register");

  a_frame_end_clears: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (cnt_q == '0) && !found_q && (col_q == '0) && (row_q == '0)
  ) else $error("accumulators not cleared after frame end");

  a_found_matches_count: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    found_q == (cnt_q != '0)
  ) else $error("found flag and changed count disagree");

  a_box_ordered: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (lx_q <= hx_q) && (ly_q <= hy_q)
  ) else $error("bounding box corners out of order");

endmodule

// ===== rtl/core/pixel_diff_bounding_box.sv =====
// ----------------------------------------------------------------------------
// pixel_diff_bounding_box: streaming frame difference with bounding box
// Holds the configuration registers and joins the compare stage to the
// frame accumulator.
// ----------------------------------------------------------------------------
// Throughput: one pixel pair per cycle; a frame's last pair is held in the compare
//   register, and input stalls, while the previous frame's result sits stalled.
// Pipeline: two register stages (compare register, then result register); the
//   result is offered in the cycle after the accumulator takes the frame's last pair.
// Reset: tolerance 0, frame 640 x 480, position and accumulators cleared,
//   no request pending on either side.
module pixel_diff_bounding_box
  import pdbb_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  pdbb_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pdbb_out_t             out_data_o
);

  logic [TOL_W-1:0]  tolerance_q;
  logic [SIZE_W-1:0] frame_width_q, frame_height_q;
  pdbb_stage_t       stage;
  logic              advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q    <= TOL_RESET;
      frame_width_q  <= WIDTH_RESET;
      frame_height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TOLERANCE:    tolerance_q    <= cfg_data_i[TOL_W-1:0];
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  pdbb_diff u_diff (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tolerance_i (tolerance_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .advance_i   (advance),
    .stage_o     (stage)
  );

  pdbb_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_accum (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .stage_i        (stage),
    .advance_o      (advance),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

endmodule
